FILE: rtl/core/spi_clock_prescaler_search_defines.svh
// ----------------------------------------------------------------------------
// Serial clock prescaler search - assertion macros
// Shared property wrappers for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef SPI_CLOCK_PRESCALER_SEARCH_DEFINES_SVH
`define SPI_CLOCK_PRESCALER_SEARCH_DEFINES_SVH

// Check a property outside reset.
`define SPCPS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SPCPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/spcps_pkg.sv
// ----------------------------------------------------------------------------
// Serial clock prescaler search - package
// Widths, constants and shared types of the prescaler search block.
// ----------------------------------------------------------------------------
`default_nettype none

package spcps_pkg;

   localparam int RATE_W = 31;
   localparam int CLK_W  = 31;
   localparam int PRE_W  = 8;
   localparam int DIV_W  = 8;
   localparam int DSOR_W = PRE_W + RATE_W;

   localparam logic [CLK_W-1:0] CLK_RESET_HZ  = 31'd133000000;
   localparam logic [PRE_W-1:0] PRESCALE_MIN  = 8'd2;
   localparam logic [PRE_W-1:0] PRESCALE_MAX  = 8'd254;
   localparam logic [PRE_W-1:0] PRESCALE_STEP = 8'd2;
   localparam logic [DIV_W-1:0] DIVIDER_MAX   = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START1,
      ST_WAIT1,
      ST_START2,
      ST_WAIT2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [CLK_W-1:0]  dividend;
      logic [DSOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CLK_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/spcps_div.sv
// ----------------------------------------------------------------------------
// Serial clock prescaler search - divider
// Restoring divider, one quotient bit per cycle, shared by all trials.
// ----------------------------------------------------------------------------
`default_nettype none

module spcps_div (
   input  wire                       clock,
   input  wire                       reset,
   input  spcps_pkg::div_req_type    req,
   output spcps_pkg::div_rsp_type    rsp
);

   localparam int STEPS = spcps_pkg::CLK_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam int DW    = spcps_pkg::DSOR_W;
   localparam int QW    = spcps_pkg::CLK_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dsor_ff, dsor_in;
   logic [QW-1:0]    quo_ff, quo_in;

   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[QW-1]};
   assign diff  = trial - {1'b0, dsor_ff};
   assign fits  = trial >= {1'b0, dsor_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
         rem_in  = '0;
         dsor_in = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quo_ff  <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

FILE: rtl/core/spi_clock_prescaler_search.sv
// ----------------------------------------------------------------------------
// Serial clock prescaler search - top level
// Finds the first even prescaler and rate divider that meet a requested rate.
// ----------------------------------------------------------------------------
// One request is handled at a time and req_tready is low until its result is
// loaded into the output register. Each prescaler tried costs one 31-step pass
// of the shared restoring divider plus set-up and check; a prescaler that passes
// that check costs a second divide. A search tries from one prescaler up to all
// 127; a zero rate answers without a divide. A new request is taken while the
// previous result still waits on rsp_tready.
`default_nettype none

module spi_clock_prescaler_search (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [30:0] baud_rate
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] prescale_divisor, [15:8] rate_divider
   output logic        rsp_tuser,   // [0] slowest_fallback
   input  wire         csr_we,
   input  wire  [30:0] csr_wdata
);

   localparam int RW = spcps_pkg::RATE_W;
   localparam int CW = spcps_pkg::CLK_W;
   localparam int PW = spcps_pkg::PRE_W;
   localparam int VW = spcps_pkg::DIV_W;
   localparam int DW = spcps_pkg::DSOR_W;

   spcps_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]          clk_hz_ff;
   logic [RW-1:0]          rate_ff, rate_in;
   logic [PW-1:0]          pre_ff, pre_in;
   logic [VW-1:0]          dval_ff, dval_in;
   logic [PW-1:0]          res_pre_ff, res_pre_in;
   logic [VW-1:0]          res_div_ff, res_div_in;
   logic                   res_flag_ff, res_flag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]          rsp_pre_ff, rsp_pre_in;
   logic [VW-1:0]          rsp_div_ff, rsp_div_in;
   logic                   rsp_flag_ff, rsp_flag_in;

   spcps_pkg::div_req_type div_req;
   spcps_pkg::div_rsp_type div_rsp;

   logic [RW-1:0]          mul_b;
   logic [CW-1:0]          dec_q;
   logic                   bump;

   spcps_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign mul_b = (state_ff == spcps_pkg::ST_START2) ?
                  RW'({1'b0, dval_ff} + (VW + 1)'(1)) : rate_ff;
   assign dec_q = (div_rsp.quotient == '0) ? '0 : div_rsp.quotient - CW'(1);
   assign bump  = div_rsp.quotient > rate_ff;

   always_comb begin
      state_in     = state_ff;
      rate_in      = rate_ff;
      pre_in       = pre_ff;
      dval_in      = dval_ff;
      res_pre_in   = res_pre_ff;
      res_div_in   = res_div_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_pre_in   = rsp_pre_ff;
      rsp_div_in   = rsp_div_ff;
      rsp_flag_in  = rsp_flag_ff;
      div_req.start    = 1'b0;
      div_req.dividend = clk_hz_ff;
      div_req.divisor  = DW'(pre_ff) * DW'(mul_b);
      req_tready   = 1'b0;

      unique case (state_ff)
         spcps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rate_in = req_tdata[RW-1:0];
               pre_in  = spcps_pkg::PRESCALE_MIN;
               if (req_tdata[RW-1:0] == '0) begin
                  res_pre_in  = spcps_pkg::PRESCALE_MAX;
                  res_div_in  = spcps_pkg::DIVIDER_MAX;
                  res_flag_in = 1'b1;
                  state_in    = spcps_pkg::ST_DONE;
               end else begin
                  state_in = spcps_pkg::ST_START1;
               end
            end
         end
         spcps_pkg::ST_START1: begin
            div_req.start = 1'b1;
            state_in      = spcps_pkg::ST_WAIT1;
         end
         spcps_pkg::ST_WAIT1: begin
            if (div_rsp.done) begin
               dval_in = dec_q[VW-1:0];
               if (dec_q > CW'(spcps_pkg::DIVIDER_MAX)) begin
                  if (pre_ff == spcps_pkg::PRESCALE_MAX) begin
                     res_pre_in  = spcps_pkg::PRESCALE_MAX;
                     res_div_in  = spcps_pkg::DIVIDER_MAX;
                     res_flag_in = 1'b1;
                     state_in    = spcps_pkg::ST_DONE;
                  end else begin
                     pre_in   = pre_ff + spcps_pkg::PRESCALE_STEP;
                     state_in = spcps_pkg::ST_START1;
                  end
               end else begin
                  state_in = spcps_pkg::ST_START2;
               end
            end
         end
         spcps_pkg::ST_START2: begin
            div_req.start = 1'b1;
            state_in      = spcps_pkg::ST_WAIT2;
         end
         spcps_pkg::ST_WAIT2: begin
            if (div_rsp.done) begin
               if (bump && (dval_ff == spcps_pkg::DIVIDER_MAX)) begin
                  if (pre_ff == spcps_pkg::PRESCALE_MAX) begin
                     res_pre_in  = spcps_pkg::PRESCALE_MAX;
                     res_div_in  = spcps_pkg::DIVIDER_MAX;
                     res_flag_in = 1'b1;
                     state_in    = spcps_pkg::ST_DONE;
                  end else begin
                     pre_in   = pre_ff + spcps_pkg::PRESCALE_STEP;
                     state_in = spcps_pkg::ST_START1;
                  end
               end else begin
                  res_pre_in  = pre_ff;
                  res_div_in  = dval_ff + VW'(bump);
                  res_flag_in = 1'b0;
                  state_in    = spcps_pkg::ST_DONE;
               end
            end
         end
         spcps_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pre_in   = res_pre_ff;
               rsp_div_in   = res_div_ff;
               rsp_flag_in  = res_flag_ff;
               state_in     = spcps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spcps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spcps_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clk_hz_ff    <= spcps_pkg::CLK_RESET_HZ;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            clk_hz_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rate_ff     <= rate_in;
      pre_ff      <= pre_in;
      dval_ff     <= dval_in;
      res_pre_ff  <= res_pre_in;
      res_div_ff  <= res_div_in;
      res_flag_ff <= res_flag_in;
      rsp_pre_ff  <= rsp_pre_in;
      rsp_div_ff  <= rsp_div_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_div_ff, rsp_pre_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule

`default_nettype wire

FILE: rtl/core/spcps_checker.sv
// ----------------------------------------------------------------------------
// Serial clock prescaler search - port checker
// Watches the top-level ports and flags results or handshakes out of shape.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spi_clock_prescaler_search_defines.svh"

module spcps_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata,
   input wire        rsp_tuser
);

   `SPCPS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `SPCPS_ASSERT(a_pre_even, clock, reset, rsp_tvalid |-> !rsp_tdata[0] && (rsp_tdata[7:1] != 7'd0) && (rsp_tdata[7:0] != 8'd0), "prescaler not even in range")
   `SPCPS_ASSERT(a_fallback, clock, reset, rsp_tvalid && rsp_tuser |-> (rsp_tdata[7:0] == 8'd254) && (rsp_tdata[15:8] == 8'd255), "fallback not slowest setting")
   `SPCPS_ASSERT(a_busy, clock, reset, req_tvalid && req_tready |=> !req_tready, "request taken while busy")
   `SPCPS_ASSERT_ALWAYS(a_reset, clock, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind spi_clock_prescaler_search spcps_checker u_spcps_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Serial clock prescaler search - testbench
// Drives requested rates through the request stream under several peripheral
// clock settings and checks each prescaler, rate divider and fallback flag
// against a search computed here with exact 64-bit arithmetic. Random idling
// on both streams, a long response hold and drained pauses between settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [spcps_pkg::PRE_W-1:0] prescale;
      logic [spcps_pkg::DIV_W-1:0] divider;
      logic                        fallback;
   } divider_setting_type;

   class prescaler_board_type;
      logic [spcps_pkg::CLK_W-1:0] clock_hz;
      divider_setting_type         pending[$];
      int                          errors;

      function new();
         clock_hz = spcps_pkg::CLK_RESET_HZ;
         errors   = 0;
      endfunction

      function divider_setting_type search(logic [spcps_pkg::RATE_W-1:0] rate);
         longint unsigned     clk;
         longint unsigned     r;
         longint unsigned     p;
         longint unsigned     d;
         divider_setting_type s;
         clk = clock_hz;
         r   = rate;
         s   = '{spcps_pkg::PRESCALE_MAX, spcps_pkg::DIVIDER_MAX, 1'b1};
         if (r == 0) return s;
         for (p = spcps_pkg::PRESCALE_MIN; p <= spcps_pkg::PRESCALE_MAX;
              p += spcps_pkg::PRESCALE_STEP) begin
            d = clk / (p * r);
            if (d != 0) d--;
            if (clk / (p * (d + 1)) > r) d++;
            if (d <= spcps_pkg::DIVIDER_MAX) begin
               s.prescale = p[spcps_pkg::PRE_W-1:0];
               s.divider  = d[spcps_pkg::DIV_W-1:0];
               s.fallback = 1'b0;
               return s;
            end
         end
         return s;
      endfunction

      function void note_request(logic [spcps_pkg::RATE_W-1:0] rate);
         pending.push_back(search(rate));
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_result(logic [15:0] data, logic user);
         divider_setting_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unrequested transaction data=%h user=%b", data, user));
            return;
         end
         want = pending.pop_front();
         if (data[7:0] !== want.prescale)
            report_mismatch($sformatf("clock %0d: prescale %0d, want %0d",
                                      clock_hz, data[7:0], want.prescale));
         if (data[15:8] !== want.divider)
            report_mismatch($sformatf("clock %0d: divider %0d, want %0d",
                                      clock_hz, data[15:8], want.divider));
         if (user !== want.fallback)
            report_mismatch($sformatf("clock %0d: fallback %b, want %b",
                                      clock_hz, user, want.fallback));
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we     = 1'b0;
   logic [30:0] csr_wdata  = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles  = 0;
   int cycle_count   = 0;

   prescaler_board_type board = new();

   logic [spcps_pkg::RATE_W-1:0] corner_rates[16] = '{
      31'd0, 31'd1, 31'd2045, 31'd2046, 31'd2047, 31'd259765, 31'd259766,
      31'd66499999, 31'd66500000, 31'd66500001, 31'd133000000, 31'h7FFFFFFF,
      31'h2AAAAAAA, 31'h55555555, 31'd1000000, 31'd12345
   };

   spi_clock_prescaler_search u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // check accepted transactions, then pick next ready; a pending hold wins
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser);
      if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles--;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic logic [spcps_pkg::RATE_W-1:0] random_rate();
      logic [31:0] raw;
      raw = $urandom;
      if ($urandom_range(0, 19) == 0) return '0;
      return 31'(raw >> $urandom_range(1, 24));
   endfunction

   task automatic send_rate(input logic [spcps_pkg::RATE_W-1:0] rate);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rate};
      do @(posedge clock); while (!req_tready);
      board.note_request(rate);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_rate(random_rate());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending.size() != 0);
   endtask

   task automatic write_clock(input logic [spcps_pkg::CLK_W-1:0] hz);
      csr_we    <= 1'b1;
      csr_wdata <= hz;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.clock_hz = hz;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 26;
      recv_idle_pct = 77;
      foreach (corner_rates[i]) send_rate(corner_rates[i]);
      send_random(20);
      drain();

      write_clock(31'h7FFFFFFF);
      send_idle_pct = 77;
      recv_idle_pct = 26;
      send_rate(31'd0);
      send_rate(31'd1);
      send_rate(31'd33026);
      send_rate(31'h7FFFFFFF);
      send_random(20);
      drain();

      // hold responses off so the block backs up onto its request side
      write_clock(31'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_cycles  = 2500;
      send_rate(31'd1);
      send_rate(31'h7FFFFFFF);
      send_rate(31'd0);
      send_random(10);
      drain();

      write_clock(31'd0);
      send_rate(31'd0);
      send_rate(31'h7FFFFFFF);
      send_random(4);
      drain();

      write_clock(31'($urandom_range(1000000, 400000000)));
      send_idle_pct = 26;
      recv_idle_pct = 77;
      send_random(20);
      drain();

      write_clock(spcps_pkg::CLK_RESET_HZ);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(20);
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/spcps_pkg.sv
rtl/core/spcps_div.sv
rtl/core/spi_clock_prescaler_search.sv
rtl/core/spcps_checker.sv
tb/tb.sv
